>>> hw/rtl/cges_pkg.sv
// Types, stage map and arithmetic helpers for the central gravity Euler step.
package cges_pkg;

  localparam int unsigned RT_STEPS = 32;
  localparam int unsigned GD_STEPS = 31;
  localparam int unsigned AD_STEPS = 31;

  localparam int unsigned ST_LOAD  = 0;
  localparam int unsigned ST_SQ    = ST_LOAD + 1;
  localparam int unsigned ST_SUM   = ST_SQ + 1;
  localparam int unsigned ST_RT0   = ST_SUM + 1;
  localparam int unsigned ST_RSQ   = ST_RT0 + RT_STEPS;
  localparam int unsigned ST_GINIT = ST_RSQ + 1;
  localparam int unsigned ST_GD0   = ST_GINIT + 1;
  localparam int unsigned ST_G     = ST_GD0 + GD_STEPS;
  localparam int unsigned ST_NUM   = ST_G + 1;
  localparam int unsigned ST_AD0   = ST_NUM + 1;
  localparam int unsigned ST_DV    = ST_AD0 + AD_STEPS;
  localparam int unsigned ST_VEL   = ST_DV + 1;
  localparam int unsigned ST_DP    = ST_VEL + 1;
  localparam int unsigned ST_POS   = ST_DP + 1;
  localparam int unsigned ST_SQ2   = ST_POS + 1;
  localparam int unsigned ST_SUM2  = ST_SQ2 + 1;
  localparam int unsigned ST_RT2   = ST_SUM2 + 1;
  localparam int unsigned ST_OUT   = ST_RT2 + RT_STEPS;
  localparam int unsigned NSTAGE   = ST_OUT + 1;

  localparam logic [31:0] MASS_RST    = 32'd65536;
  localparam logic [31:0] STEP_RST    = 32'd655;
  localparam logic [31:0] HORIZON_RST = 32'd131072;

  typedef enum logic [1:0] {
    REG_MASS    = 2'd0,
    REG_STEP    = 2'd1,
    REG_HORIZON = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic [31:0]        age_in;
    logic               alive_in;
  } in_t;

  typedef struct packed {
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
    logic signed [31:0] new_pos_z;
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
    logic signed [31:0] new_vel_z;
    logic [31:0]        age_out;
    logic               alive_out;
    logic               captured;
  } out_t;

  typedef struct packed {
    logic [2:0][31:0] pos;
    logic [2:0][31:0] vel;
    logic [31:0]      age;
    logic             alive;
    logic [2:0][63:0] sq;
    logic [63:0]      srad;
    logic [32:0]      rt_rem;
    logic [31:0]      rt_root;
    logic [31:0]      rad;
    logic [63:0]      den;
    logic             gsat;
    logic             rzero;
    logic [63:0]      gd_rem;
    logic [30:0]      gq;
    logic [30:0]      g;
    logic [2:0][61:0] num;
    logic [2:0][31:0] ad_rem;
    logic [2:0][30:0] aq;
    logic [2:0][62:0] dv;
    logic [2:0][31:0] vnew;
    logic [2:0][63:0] dp;
    logic [2:0][31:0] pnew;
  } st_t;

  function automatic logic [31:0] mag32(input logic [31:0] x);
    return x[31] ? 32'(-x) : x;
  endfunction

  function automatic logic [31:0] sat32(input logic signed [49:0] x);
    if (x > 50'sd2147483647) return 32'h7fff_ffff;
    else if (x < -50'sd2147483648) return 32'h8000_0000;
    else return x[31:0];
  endfunction

  function automatic st_t load_fn(input in_t d);
    st_t r;
    r = '0;
    r.pos[0] = d.pos_x;
    r.pos[1] = d.pos_y;
    r.pos[2] = d.pos_z;
    r.vel[0] = d.vel_x;
    r.vel[1] = d.vel_y;
    r.vel[2] = d.vel_z;
    r.age    = d.age_in;
    r.alive  = d.alive_in;
    return r;
  endfunction

  function automatic st_t stage_fn(input int unsigned k, input st_t s,
                                   input logic [31:0] mass, input logic [31:0] step);
    st_t                r;
    logic [31:0]        m;
    logic [63:0]        sh;
    logic [34:0]        rt_t;
    logic [34:0]        rt_try;
    logic [64:0]        gd_t;
    logic [61:0]        nb;
    logic [32:0]        ad_t;
    logic [30:0]        amag;
    logic [62:0]        prod;
    logic signed [49:0] acc;
    logic signed [49:0] delta;
    int unsigned        j;
    r = s;
    if (k == ST_SQ || k == ST_SQ2) begin
      for (int i = 0; i < 3; i++) begin
        m = (k == ST_SQ) ? mag32(s.pos[i]) : mag32(s.pnew[i]);
        r.sq[i] = 64'(m) * 64'(m);
      end
    end else if (k == ST_SUM || k == ST_SUM2) begin
      r.srad    = s.sq[0] + s.sq[1] + s.sq[2];
      r.rt_rem  = '0;
      r.rt_root = '0;
    end else if ((k >= ST_RT0 && k < ST_RT0 + RT_STEPS) ||
                 (k >= ST_RT2 && k < ST_RT2 + RT_STEPS)) begin
      j      = (k >= ST_RT2) ? k - ST_RT2 : k - ST_RT0;
      sh     = s.srad << (2 * j);
      rt_t   = {s.rt_rem, sh[63:62]};
      rt_try = {1'b0, s.rt_root, 2'b01};
      if (rt_t >= rt_try) begin
        r.rt_rem  = 33'(rt_t - rt_try);
        r.rt_root = {s.rt_root[30:0], 1'b1};
      end else begin
        r.rt_rem  = rt_t[32:0];
        r.rt_root = {s.rt_root[30:0], 1'b0};
      end
    end else if (k == ST_RSQ) begin
      r.rad   = s.rt_root;
      r.den   = 64'(s.rt_root) * 64'(s.rt_root);
      r.rzero = (s.rt_root == '0);
    end else if (k == ST_GINIT) begin
      r.gsat   = ({31'b0, mass, 1'b0} >= s.den);
      r.gd_rem = {31'b0, mass, 1'b0};
      r.gq     = '0;
    end else if (k >= ST_GD0 && k < ST_GD0 + GD_STEPS) begin
      gd_t = {s.gd_rem, 1'b0};
      if (gd_t >= {1'b0, s.den}) begin
        r.gd_rem = 64'(gd_t - {1'b0, s.den});
        r.gq     = {s.gq[29:0], 1'b1};
      end else begin
        r.gd_rem = gd_t[63:0];
        r.gq     = {s.gq[29:0], 1'b0};
      end
    end else if (k == ST_G) begin
      r.g = s.rzero ? '0 : (s.gsat ? '1 : s.gq);
    end else if (k == ST_NUM) begin
      for (int i = 0; i < 3; i++) begin
        prod        = 63'(s.g) * 63'(mag32(s.pos[i]));
        r.num[i]    = prod[61:0];
        r.ad_rem[i] = {1'b0, prod[61:31]};
        r.aq[i]     = '0;
      end
    end else if (k >= ST_AD0 && k < ST_AD0 + AD_STEPS) begin
      j = k - ST_AD0;
      for (int i = 0; i < 3; i++) begin
        nb   = s.num[i] >> (30 - j);
        ad_t = {s.ad_rem[i], nb[0]};
        if (ad_t >= {1'b0, s.rad}) begin
          r.ad_rem[i] = 32'(ad_t - {1'b0, s.rad});
          r.aq[i]     = {s.aq[i][29:0], 1'b1};
        end else begin
          r.ad_rem[i] = ad_t[31:0];
          r.aq[i]     = {s.aq[i][29:0], 1'b0};
        end
      end
    end else if (k == ST_DV) begin
      for (int i = 0; i < 3; i++) begin
        amag    = s.rzero ? '0 : s.aq[i];
        r.dv[i] = 63'(amag) * 63'(step);
      end
    end else if (k == ST_VEL) begin
      for (int i = 0; i < 3; i++) begin
        acc   = {{18{s.vel[i][31]}}, s.vel[i]};
        delta = {3'b0, s.dv[i][62:16]};
        acc   = s.pos[i][31] ? acc + delta : acc - delta;
        r.vnew[i] = sat32(acc);
      end
    end else if (k == ST_DP) begin
      for (int i = 0; i < 3; i++) begin
        r.dp[i] = 64'(mag32(s.vnew[i])) * 64'(step);
      end
    end else if (k == ST_POS) begin
      for (int i = 0; i < 3; i++) begin
        acc   = {{18{s.pos[i][31]}}, s.pos[i]};
        delta = {2'b0, s.dp[i][63:16]};
        acc   = s.vnew[i][31] ? acc - delta : acc + delta;
        r.pnew[i] = sat32(acc);
      end
    end
    return r;
  endfunction

  function automatic out_t out_fn(input st_t s, input logic [31:0] step,
                                  input logic [31:0] horizon);
    out_t        o;
    logic [32:0] age_sum;
    logic        cap;
    age_sum = {1'b0, s.age} + {1'b0, step};
    cap     = (s.rt_root <= horizon);
    if (s.alive) begin
      o.new_pos_x = s.pnew[0];
      o.new_pos_y = s.pnew[1];
      o.new_pos_z = s.pnew[2];
      o.new_vel_x = s.vnew[0];
      o.new_vel_y = s.vnew[1];
      o.new_vel_z = s.vnew[2];
      o.age_out   = age_sum[32] ? '1 : age_sum[31:0];
      o.alive_out = !cap;
      o.captured  = cap;
    end else begin
      o.new_pos_x = s.pos[0];
      o.new_pos_y = s.pos[1];
      o.new_pos_z = s.pos[2];
      o.new_vel_x = s.vel[0];
      o.new_vel_y = s.vel[1];
      o.new_vel_z = s.vel[2];
      o.age_out   = s.age;
      o.alive_out = 1'b0;
      o.captured  = 1'b0;
    end
    return o;
  endfunction

endpackage

>>> hw/rtl/central_gravity_euler_step.sv
// Pipelined explicit Euler step of a particle under central point-mass gravity.
//
//   channel  | signals                            | direction
//   ---------+------------------------------------+----------
//   input    | in_valid, in_ready, in_data        | in
//   output   | out_valid, out_ready, out_data     | out
//   config   | cfg_write, cfg_index, cfg_data     | in
//
// One particle enters per cycle while the output is not stalled; each passes
// 140 register stages, which hold two 32-step square root chains and two
// 31-step restoring dividers.
// Reset clears all stage valid bits and loads the register defaults.
// Each stage advances when empty or when the one after it advances, so a
// stall at the output fills bubbles first and drops or repeats no transaction.
module central_gravity_euler_step (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  cges_pkg::in_t       in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output cges_pkg::out_t      out_data
);

  localparam int unsigned N = cges_pkg::NSTAGE;

  logic [31:0] gravity_mass;
  logic [31:0] step_size;
  logic [31:0] horizon_radius;

  cges_pkg::st_t stg [N-1];
  logic [N-1:0]  vld;
  logic [N:0]    adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      gravity_mass   <= cges_pkg::MASS_RST;
      step_size      <= cges_pkg::STEP_RST;
      horizon_radius <= cges_pkg::HORIZON_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        cges_pkg::REG_MASS:    gravity_mass   <= cfg_data;
        cges_pkg::REG_STEP:    step_size      <= cfg_data;
        cges_pkg::REG_HORIZON: horizon_radius <= cfg_data;
        default: ;
      endcase
    end
  end

  assign adv[N]    = out_ready;
  assign in_ready  = adv[0];
  assign out_valid = vld[N-1];

  for (genvar k = 0; k < N; k++) begin : g_ctl
    assign adv[k] = !vld[k] || adv[k+1];
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (adv[k]) begin
        if (k == 0) vld[k] <= in_valid;
        else        vld[k] <= vld[k-1];
      end
    end
  end

  for (genvar k = 0; k < N - 1; k++) begin : g_stage
    cges_pkg::st_t nxt;
    if (k == 0) begin : g_load
      assign nxt = cges_pkg::load_fn(in_data);
    end else begin : g_work
      assign nxt = cges_pkg::stage_fn(k, stg[k-1], gravity_mass, step_size);
    end
    always_ff @(posedge clk) begin
      if (adv[k]) stg[k] <= nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[N-1]) out_data <= cges_pkg::out_fn(stg[N-2], step_size, horizon_radius);
  end

endmodule

>>> hw/rtl/cges_chk.sv
// Port-level checker for the central gravity Euler step, bound to the top level.
module cges_chk (
  input logic           clk,
  input logic           rst,
  input logic           in_valid,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input cges_pkg::out_t out_data
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled output transaction changed");

  a_capture: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.captured |-> !out_data.alive_out)
    else $error("captured particle still alive");

  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output backpressure");

endmodule

bind central_gravity_euler_step cges_chk u_cges_chk (.*);

>>> sim/testbench.sv
// Self-checking testbench for the central gravity Euler step pipeline.
`timescale 1ns / 1ps

module testbench;

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned DRAIN_CYCLES = 160;
  localparam int unsigned NPHASE = 5;
  localparam int unsigned PHASE_ITEMS = 205;

  logic           clk;
  logic           rst;
  logic           cfg_write;
  logic [1:0]     cfg_index;
  logic [31:0]    cfg_data;
  logic           in_valid;
  logic           in_ready;
  cges_pkg::in_t  in_data;
  logic           out_valid;
  logic           out_ready;
  cges_pkg::out_t out_data;

  logic [31:0] mass_reg;
  logic [31:0] step_reg;
  logic [31:0] horizon_reg;

  cges_pkg::in_t  particle_q[$];
  cges_pkg::out_t step_result_q[$];
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned error_count;
  int unsigned checked_count;
  int unsigned captured_count;
  int unsigned cycle_count;

  central_gravity_euler_step dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic logic [63:0] abs64(input longint x);
    return (x < 0) ? 64'(-x) : 64'(x);
  endfunction

  function automatic longint clamp32(input longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] n);
    logic [63:0] res;
    logic [63:0] b;
    res = '0;
    b   = 64'h1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n   = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] radius_of(input longint px, input longint py,
                                            input longint pz);
    return int_sqrt(abs64(px) * abs64(px) + abs64(py) * abs64(py) +
                    abs64(pz) * abs64(pz));
  endfunction

  function automatic longint scaled_by_step(input longint x);
    logic [63:0] m;
    m = (abs64(x) * 64'(step_reg)) >> 16;
    return (x < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic cges_pkg::out_t euler_predict(input cges_pkg::in_t d);
    cges_pkg::out_t o;
    longint         p[3];
    longint         v[3];
    longint         a[3];
    logic [63:0]    r;
    logic [63:0]    g;
    logic [63:0]    m;
    logic [32:0]    age_sum;
    p[0] = d.pos_x; p[1] = d.pos_y; p[2] = d.pos_z;
    v[0] = d.vel_x; v[1] = d.vel_y; v[2] = d.vel_z;
    o.age_out   = d.age_in;
    o.alive_out = d.alive_in;
    o.captured  = 1'b0;
    if (d.alive_in) begin
      age_sum   = {1'b0, d.age_in} + {1'b0, step_reg};
      o.age_out = age_sum[32] ? 32'hffff_ffff : age_sum[31:0];
      for (int i = 0; i < 3; i++) a[i] = 0;
      r = radius_of(p[0], p[1], p[2]);
      if (r != 0) begin
        g = {mass_reg, 32'b0} / (r * r);
        if (g > 64'h7fff_ffff) g = 64'h7fff_ffff;
        for (int i = 0; i < 3; i++) begin
          m    = (g * abs64(p[i])) / r;
          a[i] = (p[i] < 0) ? longint'(m) : -longint'(m);
        end
      end
      for (int i = 0; i < 3; i++) v[i] = clamp32(v[i] + scaled_by_step(a[i]));
      for (int i = 0; i < 3; i++) p[i] = clamp32(p[i] + scaled_by_step(v[i]));
      if (radius_of(p[0], p[1], p[2]) <= 64'(horizon_reg)) begin
        o.alive_out = 1'b0;
        o.captured  = 1'b1;
      end
    end
    o.new_pos_x = p[0][31:0]; o.new_pos_y = p[1][31:0]; o.new_pos_z = p[2][31:0];
    o.new_vel_x = v[0][31:0]; o.new_vel_y = v[1][31:0]; o.new_vel_z = v[2][31:0];
    return o;
  endfunction

  function automatic logic [31:0] random_coord();
    int unsigned sh;
    case ($urandom_range(9))
      0: return $urandom();
      1: begin
        case ($urandom_range(3))
          0: return 32'h7fff_ffff;
          1: return 32'h8000_0000;
          2: return 32'h0;
          default: return 32'hffff_ffff;
        endcase
      end
      default: begin
        sh = $urandom_range(31);
        return $urandom() >>> sh | (($urandom_range(1) != 0) ? ~(32'hffff_ffff >> sh) : 32'h0);
      end
    endcase
  endfunction

  function automatic cges_pkg::in_t random_particle();
    cges_pkg::in_t d;
    d.pos_x    = random_coord();
    d.pos_y    = random_coord();
    d.pos_z    = random_coord();
    d.vel_x    = random_coord();
    d.vel_y    = random_coord();
    d.vel_z    = random_coord();
    d.age_in   = ($urandom_range(7) == 0) ? 32'hffff_ffff - $urandom_range(100000)
                                          : $urandom();
    d.alive_in = ($urandom_range(9) != 0);
    return d;
  endfunction

  function automatic cges_pkg::in_t make_particle(input logic [31:0] px,
                                                  input logic [31:0] py,
                                                  input logic [31:0] pz,
                                                  input logic [31:0] vx,
                                                  input logic [31:0] vy,
                                                  input logic [31:0] vz,
                                                  input logic [31:0] age,
                                                  input logic alive);
    cges_pkg::in_t d;
    d.pos_x = px; d.pos_y = py; d.pos_z = pz;
    d.vel_x = vx; d.vel_y = vy; d.vel_z = vz;
    d.age_in = age; d.alive_in = alive;
    return d;
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == cges_pkg::REG_MASS) mass_reg = value;
    else if (idx == cges_pkg::REG_STEP) step_reg = value;
    else if (idx == cges_pkg::REG_HORIZON) horizon_reg = value;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) step_result_q.push_back(euler_predict(in_data));
      if (!in_valid || in_ready) begin
        if (particle_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= particle_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    cges_pkg::out_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
      if (out_valid && out_ready) begin
        if (step_result_q.size() == 0) begin
          $error("result with no particle step pending");
          error_count++;
        end else begin
          want = step_result_q.pop_front();
          checked_count++;
          if (want.captured) captured_count++;
          if (out_data.new_pos_x !== want.new_pos_x) begin
            $error("new_pos_x: expected %h, got %h", want.new_pos_x, out_data.new_pos_x);
            error_count++;
          end
          if (out_data.new_pos_y !== want.new_pos_y) begin
            $error("new_pos_y: expected %h, got %h", want.new_pos_y, out_data.new_pos_y);
            error_count++;
          end
          if (out_data.new_pos_z !== want.new_pos_z) begin
            $error("new_pos_z: expected %h, got %h", want.new_pos_z, out_data.new_pos_z);
            error_count++;
          end
          if (out_data.new_vel_x !== want.new_vel_x) begin
            $error("new_vel_x: expected %h, got %h", want.new_vel_x, out_data.new_vel_x);
            error_count++;
          end
          if (out_data.new_vel_y !== want.new_vel_y) begin
            $error("new_vel_y: expected %h, got %h", want.new_vel_y, out_data.new_vel_y);
            error_count++;
          end
          if (out_data.new_vel_z !== want.new_vel_z) begin
            $error("new_vel_z: expected %h, got %h", want.new_vel_z, out_data.new_vel_z);
            error_count++;
          end
          if (out_data.age_out !== want.age_out) begin
            $error("age_out: expected %h, got %h", want.age_out, out_data.age_out);
            error_count++;
          end
          if (out_data.alive_out !== want.alive_out) begin
            $error("alive_out: expected %b, got %b", want.alive_out, out_data.alive_out);
            error_count++;
          end
          if (out_data.captured !== want.captured) begin
            $error("captured: expected %b, got %b", want.captured, out_data.captured);
            error_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    logic [31:0] mass_set[NPHASE];
    logic [31:0] step_set[NPHASE];
    logic [31:0] horizon_set[NPHASE];
    rst            = 1'b1;
    cfg_write      = 1'b0;
    cfg_index      = cges_pkg::REG_MASS;
    cfg_data       = '0;
    in_valid       = 1'b0;
    in_data        = '0;
    out_ready      = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    error_count    = 0;
    checked_count  = 0;
    captured_count = 0;
    cycle_count    = 0;
    mass_reg       = cges_pkg::MASS_RST;
    step_reg       = cges_pkg::STEP_RST;
    horizon_reg    = cges_pkg::HORIZON_RST;
    mass_set    = '{cges_pkg::MASS_RST, 32'hffff_ffff, 32'h0, 32'd1, $urandom()};
    step_set    = '{cges_pkg::STEP_RST, 32'hffff_ffff, 32'h0, 32'd65536,
                    $urandom_range(200000)};
    horizon_set = '{cges_pkg::HORIZON_RST, 32'hffff_ffff, 32'h0, 32'd0,
                    $urandom_range(1 << 20)};
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    for (int ph = 0; ph < NPHASE; ph++) begin
      if (ph != 0) begin
        write_reg(cges_pkg::REG_MASS, mass_set[ph]);
        write_reg(cges_pkg::REG_STEP, step_set[ph]);
        write_reg(cges_pkg::REG_HORIZON, horizon_set[ph]);
        write_reg(REG_UNUSED, $urandom());
      end
      case (ph % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 45; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 45; end
        default: begin send_idle_pct = 35; recv_stall_pct = 35; end
      endcase
      if (ph == 0) begin
        particle_q.push_back(make_particle(0, 0, 0, 0, 0, 0, 0, 1'b1));
        particle_q.push_back(make_particle(0, 0, 0, 32'h7fff_ffff, 32'h8000_0000, 5,
                                           32'hffff_ffff, 1'b1));
        particle_q.push_back(make_particle(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                                           32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                                           32'hffff_fd00, 1'b1));
        particle_q.push_back(make_particle(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                           32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                           0, 1'b1));
        particle_q.push_back(make_particle(32'h8000_0000, 32'h7fff_ffff, 0,
                                           32'h1234_5678, 32'hdead_beef, 0, 7, 1'b0));
        particle_q.push_back(make_particle(1, 0, 0, 0, 0, 0, 0, 1'b1));
        particle_q.push_back(make_particle(0, 32'hffff_ffff, 0, 0, 0, 0, 0, 1'b1));
        particle_q.push_back(make_particle(32'h0002_0000, 0, 0, 0, 0, 0, 0, 1'b1));
        particle_q.push_back(make_particle(32'h0002_0100, 0, 0, 0, 0, 0, 0, 1'b1));
        particle_q.push_back(make_particle(32'h000a_0000, 0, 0, 0, 32'h0000_5000, 0,
                                           32'h0001_0000, 1'b1));
        particle_q.push_back(make_particle(0, 0, 32'hfff0_0000, 0, 0, 32'h7000_0000,
                                           0, 1'b1));
        particle_q.push_back(make_particle(32'h0000_0100, 32'hffff_ff00, 32'h0000_0080,
                                           32'h8000_0000, 32'h7fff_ffff, 0, 0, 1'b1));
        particle_q.push_back(make_particle(32'h7fff_ffff, 0, 0, 0, 0, 0, 0, 1'b0));
        particle_q.push_back(make_particle(0, 0, 0, 32'hffff_ffff, 32'hffff_ffff,
                                           32'hffff_ffff, 32'hffff_ffff, 1'b0));
      end
      for (int n = 0; n < PHASE_ITEMS; n++) particle_q.push_back(random_particle());
      do @(negedge clk);
      while (particle_q.size() != 0 || in_valid || step_result_q.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clk);
    end
    $display("checked %0d particle steps, %0d captured, over %0d register settings",
             checked_count, captured_count, NPHASE);
    $display("with idle and stall mixes on both channels");
    if (error_count == 0 && step_result_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/cges_pkg.sv
hw/rtl/central_gravity_euler_step.sv
hw/rtl/cges_chk.sv
sim/testbench.sv
